/* sv/packbits_rle_decoder_macros.svh */
// Assertion macros shared by the PackBits decoder modules.
// Every macro samples on clk and is quiet while rst_n is low.
`ifndef PACKBITS_RLE_DECODER_MACROS_SVH
`define PACKBITS_RLE_DECODER_MACROS_SVH

// Same-cycle implication
`define PBRLE_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication
`define PBRLE_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* sv/pbrle_pkg.sv */
// Types and constants for the PackBits decoder.
// Used by pbrle_ctrl, pbrle_dp and packbits_rle_decoder; depends on nothing.
package pbrle_pkg;

  localparam int BYTE_W = 8;
  localparam int REP_W  = 4;

  // Control byte that does nothing
  localparam logic [BYTE_W-1:0] CTL_NOP = 8'h80;

  // What the next input byte means
  typedef enum logic [1:0] {
    MODE_CTRL   = 2'd0,
    MODE_LIT    = 2'd1,
    MODE_RUNVAL = 2'd2
  } mode_t;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic take;    // input request accepted this cycle
    logic chunk;   // emit the next chunk of a pending run
    logic status;  // emit the end-of-stream status and clear state
  } dp_cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic  out_free;      // output register can load this cycle
    mode_t mode;          // current decode mode
    logic  run_gt_chunk;  // pending run needs more than one chunk
  } dp_stat_t;

endpackage

/* sv/packbits_rle_decoder.sv */
// Top level of the streaming PackBits decoder.
// Instantiates pbrle_ctrl and pbrle_dp; depends on pbrle_pkg.
//
//   Channel | Ports                                    | Direction
//   --------+------------------------------------------+----------
//   in      | in_valid, in_stall, in_code_byte,        | request in
//           | in_end_of_stream                         |
//   out     | out_valid, out_stall, out_value,         | request out
//           | out_repeat_res, out_done_res, out_error  |
//
// A run value byte for a run of n copies is emitted in ceil(n / min(CHUNK_MAX,15))
// chunks, one per load of the single output register. The last byte of a
// stream is followed by a status request. Reset is synchronous and clears the
// decode control state at once; the payload registers are not reset.
// A stalled output holds the register and stalls the input in the same cycle.
module packbits_rle_decoder #(
  parameter int CHUNK_MAX = 8
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [pbrle_pkg::BYTE_W-1:0] in_code_byte,
  input  logic                         in_end_of_stream,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [pbrle_pkg::BYTE_W-1:0] out_value,
  output logic [pbrle_pkg::REP_W-1:0]  out_repeat_res,
  output logic                         out_done_res,
  output logic                         out_error
);
  import pbrle_pkg::*;

  dp_cmd_t  cmd;
  dp_stat_t stat;

  pbrle_ctrl u_ctrl (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_end_of_stream (in_end_of_stream),
    .in_stall         (in_stall),
    .stat_i           (stat),
    .cmd_o            (cmd)
  );

  pbrle_dp #(
    .CHUNK_MAX (CHUNK_MAX)
  ) u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd_i          (cmd),
    .stat_o         (stat),
    .in_code_byte   (in_code_byte),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_value      (out_value),
    .out_repeat_res (out_repeat_res),
    .out_done_res   (out_done_res),
    .out_error      (out_error)
  );

endmodule

/* sv/pbrle_dp.sv */
// Datapath of the PackBits decoder: decode state, run counter, output register.
// Depends on pbrle_pkg and packbits_rle_decoder_macros.svh.
`include "packbits_rle_decoder_macros.svh"

module pbrle_dp #(
  parameter int CHUNK_MAX = 8
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  pbrle_pkg::dp_cmd_t         cmd_i,
  output pbrle_pkg::dp_stat_t        stat_o,
  input  logic [pbrle_pkg::BYTE_W-1:0] in_code_byte,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic [pbrle_pkg::BYTE_W-1:0] out_value,
  output logic [pbrle_pkg::REP_W-1:0]  out_repeat_res,
  output logic                       out_done_res,
  output logic                       out_error
);
  import pbrle_pkg::*;

  // Chunk size is capped by the 4-bit repeat field
  localparam int unsigned CHUNK = (CHUNK_MAX > 15) ? 15 : ((CHUNK_MAX < 1) ? 1 : CHUNK_MAX);
  localparam logic [REP_W-1:0]  CHUNK_REP = REP_W'(CHUNK);
  localparam logic [BYTE_W-1:0] CHUNK_LEN = BYTE_W'(CHUNK);

  mode_t             mode_r, mode_nxt;
  logic [BYTE_W-1:0] literal_left_r, literal_left_nxt;
  logic [BYTE_W-1:0] run_left_r, run_left_nxt;
  logic              produced_r, produced_nxt;
  logic [BYTE_W-1:0] run_value_r, run_value_nxt;

  logic              out_valid_r, out_valid_nxt;
  logic [BYTE_W-1:0] out_value_r, out_value_nxt;
  logic [REP_W-1:0]  out_rep_r, out_rep_nxt;
  logic              out_done_r, out_done_nxt;
  logic              out_err_r, out_err_nxt;
  logic              load;

  logic              out_free;
  logic              run_gt_chunk;
  logic [REP_W-1:0]  chunk_rep;

  assign out_free     = !out_valid_r || !out_stall;
  assign run_gt_chunk = (run_left_r > CHUNK_LEN);
  // Copies in the next chunk: full chunk or what is left
  assign chunk_rep    = run_gt_chunk ? CHUNK_REP : run_left_r[REP_W-1:0];

  assign stat_o.out_free     = out_free;
  assign stat_o.mode         = mode_r;
  assign stat_o.run_gt_chunk = run_gt_chunk;

  // Decode state and result selection
  always_comb begin
    mode_nxt         = mode_r;
    literal_left_nxt = literal_left_r;
    run_left_nxt     = run_left_r;
    produced_nxt     = produced_r;
    run_value_nxt    = run_value_r;
    load             = 1'b0;
    out_value_nxt    = out_value_r;
    out_rep_nxt      = out_rep_r;
    out_done_nxt     = out_done_r;
    out_err_nxt      = out_err_r;

    if (cmd_i.status) begin
      load             = 1'b1;
      out_value_nxt    = '0;
      out_rep_nxt      = '0;
      out_done_nxt     = 1'b1;
      out_err_nxt      = (mode_r != MODE_CTRL) || !produced_r;
      mode_nxt         = MODE_CTRL;
      literal_left_nxt = '0;
      run_left_nxt     = '0;
      produced_nxt     = 1'b0;
    end else if (cmd_i.chunk) begin
      load          = 1'b1;
      out_value_nxt = run_value_r;
      out_rep_nxt   = chunk_rep;
      out_done_nxt  = 1'b0;
      out_err_nxt   = 1'b0;
      run_left_nxt  = run_left_r - BYTE_W'(chunk_rep);
    end else if (cmd_i.take) begin
      case (mode_r)
        MODE_LIT: begin
          load             = 1'b1;
          out_value_nxt    = in_code_byte;
          out_rep_nxt      = REP_W'(1);
          out_done_nxt     = 1'b0;
          out_err_nxt      = 1'b0;
          produced_nxt     = 1'b1;
          literal_left_nxt = literal_left_r - 8'd1;
          if (literal_left_r == 8'd1) begin
            mode_nxt = MODE_CTRL;
          end
        end
        MODE_RUNVAL: begin
          load          = 1'b1;
          out_value_nxt = in_code_byte;
          out_rep_nxt   = chunk_rep;
          out_done_nxt  = 1'b0;
          out_err_nxt   = 1'b0;
          run_value_nxt = in_code_byte;
          run_left_nxt  = run_left_r - BYTE_W'(chunk_rep);
          produced_nxt  = 1'b1;
          mode_nxt      = MODE_CTRL;
        end
        default: begin
          // Control byte: literal count, run count or no-op
          if (in_code_byte < CTL_NOP) begin
            literal_left_nxt = in_code_byte + 8'd1;
            mode_nxt         = MODE_LIT;
          end else if (in_code_byte > CTL_NOP) begin
            run_left_nxt = 8'(9'd257 - {1'b0, in_code_byte});
            mode_nxt     = MODE_RUNVAL;
          end else begin
            mode_nxt = MODE_CTRL;
          end
        end
      endcase
    end

    if (load) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r         <= MODE_CTRL;
      literal_left_r <= '0;
      run_left_r     <= '0;
      produced_r     <= 1'b0;
      out_valid_r    <= 1'b0;
    end else begin
      mode_r         <= mode_nxt;
      literal_left_r <= literal_left_nxt;
      run_left_r     <= run_left_nxt;
      produced_r     <= produced_nxt;
      out_valid_r    <= out_valid_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    run_value_r <= run_value_nxt;
    out_value_r <= out_value_nxt;
    out_rep_r   <= out_rep_nxt;
    out_done_r  <= out_done_nxt;
    out_err_r   <= out_err_nxt;
  end

  assign out_valid      = out_valid_r;
  assign out_value      = out_value_r;
  assign out_repeat_res = out_rep_r;
  assign out_done_res   = out_done_r;
  assign out_error      = out_err_r;

  `PBRLE_ASSERT_NOW(a_load_when_free, cmd_i.take || cmd_i.chunk || cmd_i.status, out_free, "dp: command while output register is held")
  `PBRLE_ASSERT_NOW(a_lit_count, mode_r == MODE_LIT, literal_left_r != 8'd0, "dp: literal mode with no bytes left")
  `PBRLE_ASSERT_NOW(a_run_count, mode_r == MODE_RUNVAL, (run_left_r >= 8'd2) && (run_left_r <= 8'd128), "dp: run length out of range")
  `PBRLE_ASSERT_NEXT(a_status_clears, cmd_i.status, (mode_r == MODE_CTRL) && !produced_r, "dp: state not cleared after status")

endmodule

/* sv/pbrle_ctrl.sv */
// Controller of the PackBits decoder: sequences input requests, run chunks
// and the status result. Depends on pbrle_pkg and the macros header.
`include "packbits_rle_decoder_macros.svh"

module pbrle_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  logic                in_end_of_stream,
  output logic                in_stall,
  input  pbrle_pkg::dp_stat_t stat_i,
  output pbrle_pkg::dp_cmd_t  cmd_o
);
  import pbrle_pkg::*;

  typedef enum logic [2:0] {
    ST_TAKE   = 3'b001,
    ST_RUN    = 3'b010,
    ST_STATUS = 3'b100
  } ctl_state_t;

  ctl_state_t state_r, state_nxt;
  logic       eos_r, eos_nxt;
  logic       take;

  assign in_stall = !((state_r == ST_TAKE) && stat_i.out_free);
  assign take     = in_valid && !in_stall;

  // Next state and commands
  always_comb begin
    state_nxt    = state_r;
    eos_nxt      = eos_r;
    cmd_o.take   = 1'b0;
    cmd_o.chunk  = 1'b0;
    cmd_o.status = 1'b0;
    case (state_r)
      ST_TAKE: begin
        if (take) begin
          cmd_o.take = 1'b1;
          eos_nxt    = in_end_of_stream;
          if ((stat_i.mode == MODE_RUNVAL) && stat_i.run_gt_chunk) begin
            state_nxt = ST_RUN;
          end else if (in_end_of_stream) begin
            state_nxt = ST_STATUS;
          end
        end
      end
      ST_RUN: begin
        if (stat_i.out_free) begin
          cmd_o.chunk = 1'b1;
          if (!stat_i.run_gt_chunk) begin
            state_nxt = eos_r ? ST_STATUS : ST_TAKE;
          end
        end
      end
      ST_STATUS: begin
        if (stat_i.out_free) begin
          cmd_o.status = 1'b1;
          state_nxt    = ST_TAKE;
        end
      end
      default: begin
        state_nxt = ST_TAKE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_TAKE;
      eos_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      eos_r   <= eos_nxt;
    end
  end

  `PBRLE_ASSERT_NOW(a_one_cmd, 1'b1, $onehot0({cmd_o.take, cmd_o.chunk, cmd_o.status}), "ctrl: more than one command")
  `PBRLE_ASSERT_NOW(a_busy_stalls, state_r != ST_TAKE, in_stall, "ctrl: input open while busy")
  `PBRLE_ASSERT_NEXT(a_eos_status, take && in_end_of_stream && (stat_i.mode != MODE_RUNVAL), state_r == ST_STATUS, "ctrl: last byte not followed by status")

endmodule
